### src/callsign_ssid_parser_assert.svh
// ---------------------------------------------------------------------------
// Callsign SSID parser assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef CALLSIGN_SSID_PARSER_ASSERT_SVH
`define CALLSIGN_SSID_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("callsign_ssid_parser assertion failed");
`define CSP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("callsign_ssid_parser assertion failed");
`else
`define CSP_ASSERT(label, prop)
`define CSP_ASSERT_ALWAYS(label, prop)
`endif
`endif

### src/csp_pkg.sv
// ---------------------------------------------------------------------------
// Callsign SSID parser package
// Shared constants, parse state and result types, and the base packer.
// ---------------------------------------------------------------------------
package csp_pkg;

    localparam int CALL_BUFFER_LEN = 10;
    localparam int STORE_DEPTH     = CALL_BUFFER_LEN - 1;
    localparam int CNT_W           = $clog2(STORE_DEPTH + 1);
    localparam int MAX_BASE        = 6;
    localparam int RUN_W           = 4;
    localparam int BASE_W          = 8 * MAX_BASE;

    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_Z    = 8'h7A;
    localparam logic [7:0] CHAR_TERM    = 8'h00;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] MAX_SSID     = 8'd15;

    typedef logic [MAX_BASE-1:0][7:0] t_store;

    typedef struct packed {
        t_store           store;
        logic [CNT_W-1:0] char_count;
        logic             after_sep;
        logic [3:0]       sfx_count;
        logic [7:0]       sfx_value;
        logic [RUN_W-1:0] trail_run;
        logic [3:0]       last_digit;
        logic [3:0]       prev_digit;
        logic             error;
    } t_parse_state;

    typedef struct packed {
        logic              valid_res;
        logic [BASE_W-1:0] base_call;
        logic [2:0]        base_length;
        logic              ssid_present;
        logic [3:0]        ssid_value;
    } t_result;

    function automatic logic [BASE_W-1:0] pack_base(t_store st, logic [RUN_W-1:0] len);
        logic [BASE_W-1:0] v;
        v = '0;
        for (int i = 0; i < MAX_BASE; i++) begin
            if (RUN_W'(i) < len) begin
                v[BASE_W-1-8*i -: 8] = st[i];
            end
        end
        return v;
    endfunction

endpackage

### src/csp_result.sv
// ---------------------------------------------------------------------------
// Callsign SSID parser result builder
// Turns the accumulated parse state into the final result at the terminator.
// ---------------------------------------------------------------------------
module csp_result (
    input  csp_pkg::t_parse_state i_state,
    output csp_pkg::t_result      o_result
);

    always_comb begin
        logic [csp_pkg::RUN_W-1:0] cnt;
        logic [csp_pkg::RUN_W-1:0] run;
        logic [csp_pkg::RUN_W-1:0] k;
        logic [6:0]                n;
        cnt      = csp_pkg::RUN_W'(i_state.char_count);
        run      = (i_state.trail_run > cnt) ? cnt : i_state.trail_run;
        k        = cnt - run;
        n        = (run == csp_pkg::RUN_W'(1)) ? 7'(i_state.last_digit)
                 : 7'(7'(i_state.prev_digit) * 7'd10) + 7'(i_state.last_digit);
        o_result = '0;
        if (i_state.error) begin
            o_result = '0;
        end else if (i_state.after_sep) begin
            if (i_state.sfx_count >= 4'd1 && i_state.sfx_count <= 4'd2
                && i_state.sfx_value <= csp_pkg::MAX_SSID) begin
                o_result.valid_res    = 1'b1;
                o_result.base_call    = csp_pkg::pack_base(i_state.store, cnt);
                o_result.base_length  = cnt[2:0];
                o_result.ssid_present = 1'b1;
                o_result.ssid_value   = i_state.sfx_value[3:0];
            end
        end else if (cnt <= csp_pkg::RUN_W'(csp_pkg::MAX_BASE)) begin
            if (cnt != '0) begin
                o_result.valid_res   = 1'b1;
                o_result.base_call   = csp_pkg::pack_base(i_state.store, cnt);
                o_result.base_length = cnt[2:0];
            end
        end else if (run != '0 && run <= csp_pkg::RUN_W'(2) && k != '0
                     && k <= csp_pkg::RUN_W'(csp_pkg::MAX_BASE) && n <= 7'd15) begin
            o_result.valid_res    = 1'b1;
            o_result.base_call    = csp_pkg::pack_base(i_state.store, k);
            o_result.base_length  = k[2:0];
            o_result.ssid_present = 1'b1;
            o_result.ssid_value   = n[3:0];
        end
    end

endmodule

### src/callsign_ssid_parser.sv
// ---------------------------------------------------------------------------
// Callsign SSID parser
// One character per beat; a zero character yields one parsed result beat.
// ---------------------------------------------------------------------------
// Throughput is one character per cycle while o_stall is low, limited by the single state update.
// A result appears on the output register in the cycle after its terminator is accepted.
// Characters are held off only while a result beat waits on a stalled receiver.
// Synchronous active-low reset clears the parse state and the output valid.
module callsign_ssid_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [47:0] o_base_call,
    output logic [2:0]  o_base_length,
    output logic        o_ssid_present,
    output logic [3:0]  o_ssid_value
);

    `include "callsign_ssid_parser_assert.svh"

    csp_pkg::t_parse_state r_state;
    csp_pkg::t_parse_state n_state;
    csp_pkg::t_result      r_out;
    csp_pkg::t_result      w_result;
    logic                  r_out_valid;
    logic                  w_accept;
    logic                  w_term;
    logic [7:0]            w_char;
    logic                  w_digit;
    logic                  w_alpha;
    logic [11:0]           w_sfx_next;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_term   = (i_character == csp_pkg::CHAR_TERM);

    assign w_char   = (i_character >= csp_pkg::CHAR_LO_A && i_character <= csp_pkg::CHAR_LO_Z)
                    ? i_character - csp_pkg::CASE_OFFSET : i_character;
    assign w_digit  = (w_char >= csp_pkg::CHAR_ZERO && w_char <= csp_pkg::CHAR_NINE);
    assign w_alpha  = (w_char >= csp_pkg::CHAR_UP_A && w_char <= csp_pkg::CHAR_UP_Z);
    assign w_sfx_next = 12'(12'(r_state.sfx_value) * 12'd10) + 12'(w_char[3:0]);

    always_comb begin
        n_state = r_state;
        if (w_term) begin
            n_state = '0;
        end else if (r_state.error) begin
            n_state = r_state;
        end else if (r_state.after_sep) begin
            if (!w_digit) begin
                n_state.error = 1'b1;
            end else begin
                n_state.sfx_value = (w_sfx_next > 12'd255) ? 8'hFF : w_sfx_next[7:0];
                if (r_state.sfx_count != 4'hF) begin
                    n_state.sfx_count = r_state.sfx_count + 4'd1;
                end
            end
        end else if (w_char == csp_pkg::CHAR_DASH || w_char == csp_pkg::CHAR_UNDER) begin
            if (r_state.char_count == '0
                || r_state.char_count > csp_pkg::CNT_W'(csp_pkg::MAX_BASE)) begin
                n_state.error = 1'b1;
            end else begin
                n_state.after_sep = 1'b1;
            end
        end else if (!(w_alpha || w_digit)
                     || r_state.char_count >= csp_pkg::CNT_W'(csp_pkg::STORE_DEPTH)) begin
            n_state.error = 1'b1;
        end else begin
            for (int i = 0; i < csp_pkg::MAX_BASE; i++) begin
                if (r_state.char_count == csp_pkg::CNT_W'(i)) begin
                    n_state.store[i] = w_char;
                end
            end
            n_state.char_count = r_state.char_count + csp_pkg::CNT_W'(1);
            if (w_digit) begin
                n_state.prev_digit = r_state.last_digit;
                n_state.last_digit = w_char[3:0];
                if (r_state.trail_run != '1) begin
                    n_state.trail_run = r_state.trail_run + csp_pkg::RUN_W'(1);
                end
            end else begin
                n_state.trail_run = '0;
            end
        end
    end

    csp_result u_result (
        .i_state  (r_state),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_accept && w_term) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_term) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_valid_res    = r_out.valid_res;
    assign o_base_call    = r_out.base_call;
    assign o_base_length  = r_out.base_length;
    assign o_ssid_present = r_out.ssid_present;
    assign o_ssid_value   = r_out.ssid_value;

    `CSP_ASSERT(a_term_clears, w_accept && w_term |=> r_state == '0)
    `CSP_ASSERT(a_count_bound, r_state.char_count <= csp_pkg::CNT_W'(csp_pkg::STORE_DEPTH))
    `CSP_ASSERT(a_invalid_zero, r_out_valid && !r_out.valid_res |-> r_out == '0)
    `CSP_ASSERT(a_ssid_absent, r_out_valid && !r_out.ssid_present |-> r_out.ssid_value == '0)
    `CSP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_out_valid)

endmodule
